// File: src/cub_pkg.sv
`default_nettype none

package cub_pkg;

    // request codes on the input channel
    localparam logic [1:0] REQ_SEND = 2'd0;
    localparam logic [1:0] REQ_BYTE = 2'd1;
    localparam logic [1:0] REQ_IDLE = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_SYNC_FIRST    = 2'd0;
    localparam logic [1:0] CFG_SYNC_SECOND   = 2'd1;
    localparam logic [1:0] CFG_TYPE_OUTBOUND = 2'd2;
    localparam logic [1:0] CFG_TYPE_INBOUND  = 2'd3;

    // receive report status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_LENGTH   = 3'd1;
    localparam logic [2:0] ST_SYNC     = 3'd2;
    localparam logic [2:0] ST_DLC_OVER = 3'd3;
    localparam logic [2:0] ST_CHECKSUM = 3'd4;
    localparam logic [2:0] ST_DLC_SHORT = 3'd5;

    // entries between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;

    // header bytes before the data slots
    localparam int HDR_BYTES = 6;

    typedef enum logic [1:0] {
        KIND_TX     = 2'd0,
        KIND_REPORT = 2'd1,
        KIND_REJECT = 2'd2
    } t_kind;

    typedef struct packed {
        logic [7:0] sync_first;
        logic [7:0] sync_second;
        logic [7:0] type_outbound;
        logic [7:0] type_inbound;
    } t_cfg;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] can_id;
        logic [7:0]  dlc;
        logic [63:0] data;
        logic [2:0]  status;
        logic [7:0]  chk;
        logic [31:0] sent;
        logic [31:0] good;
        logic [31:0] bad;
    } t_entry;

endpackage

`default_nettype wire

// File: src/can_over_uart_bridge_framer.sv
`default_nettype none

// CAN-over-UART framer. One item is taken per cycle on the input channel while the
// four-entry queue between the request front end and the output sequencer has room.
// A send request becomes a frame of FRAME_BYTES transmit beats, one per cycle while the
// output is not stalled, so the output port and the frame sequencer set the sustained
// rate: a send yields FRAME_BYTES output beats, a rejected send or a receive report one,
// and a received byte that does not finish a frame none. A result passes through the queue
// memory and the output register. Received bytes are checked on the fly with a running
// checksum; there is no clearing pass after reset. Counter values in each result are
// those after the item that caused it.
module can_over_uart_bridge_framer
    import cub_pkg::*;
#(
    parameter int PAYLOAD_BYTES = 8,
    parameter int FRAME_BYTES   = 15
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [7:0]  i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_req_type,
    input  wire logic [15:0] i_can_id,
    input  wire logic [7:0]  i_dlc,
    input  wire logic [63:0] i_payload,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_result_kind,
    output logic [7:0]       o_tx_byte,
    output logic             o_last,
    output logic [15:0]      o_rx_can_id,
    output logic [7:0]       o_rx_dlc,
    output logic [63:0]      o_rx_payload,
    output logic [2:0]       o_rx_status,
    output logic [31:0]      o_sent_total,
    output logic [31:0]      o_good_total,
    output logic [31:0]      o_bad_total
);

    t_cfg   r_cfg;
    logic   q_full, q_nonempty, q_push, q_pop;
    t_entry q_in, q_head;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_first    <= 8'd170;
            r_cfg.sync_second   <= 8'd85;
            r_cfg.type_outbound <= 8'd1;
            r_cfg.type_inbound  <= 8'd2;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SYNC_FIRST:    r_cfg.sync_first    <= i_cfg_data;
                CFG_SYNC_SECOND:   r_cfg.sync_second   <= i_cfg_data;
                CFG_TYPE_OUTBOUND: r_cfg.type_outbound <= i_cfg_data;
                CFG_TYPE_INBOUND:  r_cfg.type_inbound  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    cub_front #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES),
        .FRAME_BYTES   (FRAME_BYTES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_req_type (i_req_type),
        .i_can_id   (i_can_id),
        .i_dlc      (i_dlc),
        .i_payload  (i_payload),
        .i_rx_byte  (i_rx_byte),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_entry    (q_in)
    );

    cub_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (q_push),
        .i_entry    (q_in),
        .i_pop      (q_pop),
        .o_full     (q_full),
        .o_nonempty (q_nonempty),
        .o_head     (q_head)
    );

    cub_back #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_nonempty    (q_nonempty),
        .i_head        (q_head),
        .o_pop         (q_pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_result_kind (o_result_kind),
        .o_tx_byte     (o_tx_byte),
        .o_last        (o_last),
        .o_rx_can_id   (o_rx_can_id),
        .o_rx_dlc      (o_rx_dlc),
        .o_rx_payload  (o_rx_payload),
        .o_rx_status   (o_rx_status),
        .o_sent_total  (o_sent_total),
        .o_good_total  (o_good_total),
        .o_bad_total   (o_bad_total)
    );

endmodule

`default_nettype wire

// File: src/cub_front.sv
`default_nettype none

module cub_front
    import cub_pkg::*;
#(
    parameter int PAYLOAD_BYTES = 8,
    parameter int FRAME_BYTES   = 15
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cfg        i_cfg,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_req_type,
    input  wire logic [15:0] i_can_id,
    input  wire logic [7:0]  i_dlc,
    input  wire logic [63:0] i_payload,
    input  wire logic [7:0]  i_rx_byte,
    input  wire logic        i_q_full,
    output logic             o_push,
    output t_entry           o_entry
);

    localparam int FILL_W = $clog2(FRAME_BYTES);
    localparam int SLOTS  = FRAME_BYTES - HDR_BYTES - 1;

    logic [7:0]        r_buf [FRAME_BYTES];
    logic [FILL_W-1:0] r_fill, n_fill;
    logic [7:0]        r_xor, n_xor;
    logic [31:0]       r_sent, n_sent;
    logic [31:0]       r_good, n_good;
    logic [31:0]       r_bad, n_bad;

    logic        acc;
    logic [63:0] tx_data;
    logic [7:0]  tx_chk;
    logic [63:0] rx_data;
    logic [2:0]  rx_st;

    assign o_in_stall = i_q_full;
    assign acc        = i_in_valid && !i_q_full;

    // data bytes that land in the frame, the rest zero, and the frame checksum
    always_comb begin
        tx_data = '0;
        tx_chk  = i_cfg.type_outbound ^ i_can_id[7:0] ^ i_can_id[15:8] ^ i_dlc;
        for (int i = 0; i < 8; i++) begin
            if (i < PAYLOAD_BYTES && i < SLOTS && 8'(i) < i_dlc) begin
                tx_data[8*i +: 8] = i_payload[8*i +: 8];
            end
            tx_chk = tx_chk ^ tx_data[8*i +: 8];
        end
    end

    // check of a full frame, the byte coming in is the checksum
    always_comb begin
        rx_data = '0;
        for (int i = 0; i < 8; i++) begin
            if (i < SLOTS) begin
                rx_data[8*i +: 8] = r_buf[HDR_BYTES + i];
            end
        end
        if (r_buf[0] != i_cfg.sync_first || r_buf[1] != i_cfg.sync_second ||
            r_buf[2] != i_cfg.type_inbound) begin
            rx_st = ST_SYNC;
        end else if (r_buf[5] > 8'(PAYLOAD_BYTES)) begin
            rx_st = ST_DLC_OVER;
        end else if (i_rx_byte != r_xor) begin
            rx_st = ST_CHECKSUM;
        end else if (r_buf[5] != 8'(PAYLOAD_BYTES)) begin
            rx_st = ST_DLC_SHORT;
        end else begin
            rx_st = ST_OK;
        end
    end

    always_comb begin
        n_fill  = r_fill;
        n_xor   = r_xor;
        n_sent  = r_sent;
        n_good  = r_good;
        n_bad   = r_bad;
        o_push  = 1'b0;
        o_entry = '0;
        if (acc) begin
            unique case (i_req_type)
                REQ_SEND: begin
                    o_push = 1'b1;
                    if (i_dlc > 8'(PAYLOAD_BYTES)) begin
                        o_entry.kind = KIND_REJECT;
                    end else begin
                        n_sent         = r_sent + 32'd1;
                        o_entry.kind   = KIND_TX;
                        o_entry.can_id = i_can_id;
                        o_entry.dlc    = i_dlc;
                        o_entry.data   = tx_data;
                        o_entry.chk    = tx_chk;
                    end
                end
                REQ_BYTE: begin
                    if (r_fill == FILL_W'(FRAME_BYTES - 1)) begin
                        o_push         = 1'b1;
                        o_entry.kind   = KIND_REPORT;
                        o_entry.can_id = {r_buf[4], r_buf[3]};
                        o_entry.dlc    = r_buf[5];
                        o_entry.data   = rx_data;
                        o_entry.status = rx_st;
                        n_fill         = '0;
                        n_xor          = '0;
                        if (rx_st == ST_OK) begin
                            n_good = r_good + 32'd1;
                        end else begin
                            n_bad = r_bad + 32'd1;
                        end
                    end else begin
                        n_fill = r_fill + FILL_W'(1);
                        if (r_fill >= FILL_W'(2)) begin
                            n_xor = r_xor ^ i_rx_byte;
                        end
                    end
                end
                REQ_IDLE: begin
                    // buffer never holds a whole frame here
                    o_push         = 1'b1;
                    o_entry.kind   = KIND_REPORT;
                    o_entry.status = ST_LENGTH;
                    n_fill         = '0;
                    n_xor          = '0;
                    n_bad          = r_bad + 32'd1;
                end
                default: begin
                end
            endcase
        end
        o_entry.sent = n_sent;
        o_entry.good = n_good;
        o_entry.bad  = n_bad;
    end

    always_ff @(posedge i_clk) begin
        if (acc && i_req_type == REQ_BYTE) begin
            r_buf[r_fill] <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_xor  <= '0;
            r_sent <= '0;
            r_good <= '0;
            r_bad  <= '0;
        end else begin
            r_fill <= n_fill;
            r_xor  <= n_xor;
            r_sent <= n_sent;
            r_good <= n_good;
            r_bad  <= n_bad;
        end
    end

endmodule

`default_nettype wire

// File: src/cub_queue.sv
`default_nettype none

module cub_queue
    import cub_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_entry i_entry,
    input  wire logic   i_pop,
    output logic        o_full,
    output logic        o_nonempty,
    output t_entry      o_head
);

    t_entry             r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr, r_rd;
    logic [Q_PTR_W:0]   r_cnt;
    logic               do_push, do_pop;

    assign o_full     = (r_cnt == (Q_PTR_W + 1)'(Q_DEPTH));
    assign o_nonempty = (r_cnt != '0);
    assign o_head     = r_mem[r_rd];
    assign do_push    = i_push && !o_full;
    assign do_pop     = i_pop && o_nonempty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + Q_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + Q_PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + (Q_PTR_W + 1)'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - (Q_PTR_W + 1)'(1);
            end
        end
    end

endmodule

`default_nettype wire

// File: src/cub_back.sv
`default_nettype none

module cub_back
    import cub_pkg::*;
#(
    parameter int FRAME_BYTES = 15
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cfg        i_cfg,
    input  wire logic        i_nonempty,
    input  wire t_entry      i_head,
    output logic             o_pop,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_result_kind,
    output logic [7:0]       o_tx_byte,
    output logic             o_last,
    output logic [15:0]      o_rx_can_id,
    output logic [7:0]       o_rx_dlc,
    output logic [63:0]      o_rx_payload,
    output logic [2:0]       o_rx_status,
    output logic [31:0]      o_sent_total,
    output logic [31:0]      o_good_total,
    output logic [31:0]      o_bad_total
);

    localparam int FILL_W = $clog2(FRAME_BYTES);

    logic [FILL_W-1:0] r_idx, n_idx;
    logic              r_valid;
    logic              fire, is_tx, at_end;
    logic [2:0]        slot;
    logic [7:0]        frame_byte;

    assign fire   = i_nonempty && (!r_valid || !i_out_stall);
    assign is_tx  = (i_head.kind == KIND_TX);
    assign at_end = (r_idx == FILL_W'(FRAME_BYTES - 1));
    assign o_pop  = fire && (!is_tx || at_end);
    assign slot   = 3'(r_idx - FILL_W'(HDR_BYTES));
    assign o_out_valid = r_valid;

    always_comb begin
        if (r_idx == FILL_W'(0)) begin
            frame_byte = i_cfg.sync_first;
        end else if (r_idx == FILL_W'(1)) begin
            frame_byte = i_cfg.sync_second;
        end else if (r_idx == FILL_W'(2)) begin
            frame_byte = i_cfg.type_outbound;
        end else if (r_idx == FILL_W'(3)) begin
            frame_byte = i_head.can_id[7:0];
        end else if (r_idx == FILL_W'(4)) begin
            frame_byte = i_head.can_id[15:8];
        end else if (r_idx == FILL_W'(5)) begin
            frame_byte = i_head.dlc;
        end else if (at_end) begin
            frame_byte = i_head.chk;
        end else begin
            frame_byte = i_head.data[{slot, 3'b000} +: 8];
        end
    end

    always_comb begin
        n_idx = r_idx;
        if (fire && is_tx) begin
            n_idx = at_end ? '0 : r_idx + FILL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_valid <= fire || (r_valid && i_out_stall);
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            o_result_kind <= i_head.kind;
            o_sent_total  <= i_head.sent;
            o_good_total  <= i_head.good;
            o_bad_total   <= i_head.bad;
            if (is_tx) begin
                o_tx_byte    <= frame_byte;
                o_last       <= at_end;
                o_rx_can_id  <= '0;
                o_rx_dlc     <= '0;
                o_rx_payload <= '0;
                o_rx_status  <= '0;
            end else begin
                o_tx_byte    <= '0;
                o_last       <= 1'b0;
                o_rx_can_id  <= i_head.can_id;
                o_rx_dlc     <= i_head.dlc;
                o_rx_payload <= i_head.data;
                o_rx_status  <= i_head.status;
            end
        end
    end

endmodule

`default_nettype wire

// File: tb/sv/framer_monitor.sv
`timescale 1ns / 1ps

module framer_monitor
    import cub_pkg::*;
#(
    parameter int PAYLOAD_BYTES = 8,
    parameter int FRAME_BYTES   = 15
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    input  wire logic        i_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [7:0]  i_cfg_data,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_stall,
    input  wire logic [1:0]  i_req_type,
    input  wire logic [15:0] i_can_id,
    input  wire logic [7:0]  i_dlc,
    input  wire logic [63:0] i_payload,
    input  wire logic [7:0]  i_rx_byte,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_stall,
    input  wire logic [1:0]  i_result_kind,
    input  wire logic [7:0]  i_tx_byte,
    input  wire logic        i_last,
    input  wire logic [15:0] i_rx_can_id,
    input  wire logic [7:0]  i_rx_dlc,
    input  wire logic [63:0] i_rx_payload,
    input  wire logic [2:0]  i_rx_status,
    input  wire logic [31:0] i_sent_total,
    input  wire logic [31:0] i_good_total,
    input  wire logic [31:0] i_bad_total,
    output int               o_fail_count,
    output int               o_pending
);

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  tx_byte;
        logic        last;
        logic [15:0] can_id;
        logic [7:0]  dlc;
        logic [63:0] data;
        logic [2:0]  status;
        logic [31:0] sent;
        logic [31:0] good;
        logic [31:0] bad;
    } t_bridge_beat;

    t_cfg         cfg_shadow;
    logic [7:0]   rx_frame [FRAME_BYTES];
    int           rx_fill;
    logic [31:0]  sent_cnt;
    logic [31:0]  good_cnt;
    logic [31:0]  bad_cnt;
    t_bridge_beat owed_beats [$];
    t_bridge_beat want_beat;
    t_bridge_beat seen_beat;
    int           fail_cnt = 0;

    // counters are taken as they stand once the request has updated them
    function automatic t_bridge_beat make_beat(input logic [1:0] kind);
        t_bridge_beat b;
        b      = '0;
        b.kind = kind;
        b.sent = sent_cnt;
        b.good = good_cnt;
        b.bad  = bad_cnt;
        return b;
    endfunction

    function automatic string beat_text(input t_bridge_beat b);
        return {$sformatf("kind %0d tx %02h last %0b id %04h dlc %02h ",
                          b.kind, b.tx_byte, b.last, b.can_id, b.dlc),
                $sformatf("data %016h st %0d sent %0d good %0d bad %0d",
                          b.data, b.status, b.sent, b.good, b.bad)};
    endfunction

    task automatic frame_send(input logic [15:0] id, input logic [7:0] dlc,
                              input logic [63:0] data);
        logic [7:0]   frame [FRAME_BYTES];
        logic [7:0]   sum;
        t_bridge_beat b;
        if (dlc > PAYLOAD_BYTES) begin
            owed_beats.push_back(make_beat(KIND_REJECT));
            return;
        end
        for (int k = 0; k < FRAME_BYTES; k++) frame[k] = 8'h00;
        frame[0] = cfg_shadow.sync_first;
        frame[1] = cfg_shadow.sync_second;
        frame[2] = cfg_shadow.type_outbound;
        frame[3] = id[7:0];
        frame[4] = id[15:8];
        frame[5] = dlc;
        // slots past the dlc stay zero
        for (int i = 0; HDR_BYTES + i < FRAME_BYTES - 1; i++) begin
            if (i < 8 && i < dlc && i < PAYLOAD_BYTES) frame[HDR_BYTES + i] = data[8*i +: 8];
        end
        sum = 8'h00;
        for (int i = 2; i < FRAME_BYTES - 1; i++) sum ^= frame[i];
        frame[FRAME_BYTES - 1] = sum;
        sent_cnt = sent_cnt + 32'd1;
        for (int k = 0; k < FRAME_BYTES; k++) begin
            b         = make_beat(KIND_TX);
            b.tx_byte = frame[k];
            b.last    = (k == FRAME_BYTES - 1);
            owed_beats.push_back(b);
        end
    endtask

    task automatic frame_check();
        logic [15:0]  id;
        logic [7:0]   dlc;
        logic [63:0]  data;
        logic [7:0]   sum;
        logic [2:0]   st;
        t_bridge_beat b;
        id   = '0;
        dlc  = '0;
        data = '0;
        if (rx_fill != FRAME_BYTES) begin
            st = ST_LENGTH;
        end else begin
            id  = {rx_frame[4], rx_frame[3]};
            dlc = rx_frame[5];
            for (int i = 0; HDR_BYTES + i < FRAME_BYTES - 1 && i < 8; i++)
                data[8*i +: 8] = rx_frame[HDR_BYTES + i];
            sum = 8'h00;
            for (int i = 2; i < FRAME_BYTES - 1; i++) sum ^= rx_frame[i];
            // first failing check wins
            if (rx_frame[0] != cfg_shadow.sync_first || rx_frame[1] != cfg_shadow.sync_second
                    || rx_frame[2] != cfg_shadow.type_inbound)
                st = ST_SYNC;
            else if (dlc > PAYLOAD_BYTES)
                st = ST_DLC_OVER;
            else if (rx_frame[FRAME_BYTES - 1] != sum)
                st = ST_CHECKSUM;
            else if (dlc != PAYLOAD_BYTES)
                st = ST_DLC_SHORT;
            else
                st = ST_OK;
        end
        if (st == ST_OK) good_cnt = good_cnt + 32'd1;
        else bad_cnt = bad_cnt + 32'd1;
        rx_fill  = 0;
        b        = make_beat(KIND_REPORT);
        b.can_id = id;
        b.dlc    = dlc;
        b.data   = data;
        b.status = st;
        owed_beats.push_back(b);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_shadow = {8'd170, 8'd85, 8'd1, 8'd2};
            rx_fill    = 0;
            sent_cnt   = '0;
            good_cnt   = '0;
            bad_cnt    = '0;
            owed_beats.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SYNC_FIRST:    cfg_shadow.sync_first    = i_cfg_data;
                    CFG_SYNC_SECOND:   cfg_shadow.sync_second   = i_cfg_data;
                    CFG_TYPE_OUTBOUND: cfg_shadow.type_outbound = i_cfg_data;
                    CFG_TYPE_INBOUND:  cfg_shadow.type_inbound  = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                case (i_req_type)
                    REQ_SEND: frame_send(i_can_id, i_dlc, i_payload);
                    REQ_BYTE: begin
                        if (rx_fill < FRAME_BYTES) begin
                            rx_frame[rx_fill] = i_rx_byte;
                            rx_fill++;
                        end
                        if (rx_fill >= FRAME_BYTES) frame_check();
                    end
                    REQ_IDLE: frame_check();
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                seen_beat = {i_result_kind, i_tx_byte, i_last, i_rx_can_id, i_rx_dlc,
                             i_rx_payload, i_rx_status, i_sent_total, i_good_total,
                             i_bad_total};
                if (owed_beats.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display("%0t: result beat with nothing outstanding: %s",
                                 $time, beat_text(seen_beat));
                end else begin
                    want_beat = owed_beats.pop_front();
                    if (seen_beat !== want_beat) begin
                        fail_cnt++;
                        if (fail_cnt <= 10) begin
                            $display("%0t: result beat mismatch", $time);
                            $display("  expected %s", beat_text(want_beat));
                            $display("  actual   %s", beat_text(seen_beat));
                        end
                    end
                end
            end
        end
        o_pending    <= owed_beats.size();
        o_fail_count <= fail_cnt;
    end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import cub_pkg::*;

    localparam int PAYLOAD_BYTES = 8;
    localparam int FRAME_BYTES   = 15;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 12;

    // request code the block ignores
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    typedef enum int {
        FLAW_NONE,
        FLAW_SYNC_FIRST,
        FLAW_SYNC_SECOND,
        FLAW_TYPE,
        FLAW_DLC_OVER,
        FLAW_DLC_SHORT,
        FLAW_CHECKSUM,
        FLAW_TRUNCATE
    } t_flaw;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [7:0]  cfg_data  = '0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    logic [1:0]  req_type  = '0;
    logic [15:0] can_id    = '0;
    logic [7:0]  dlc       = '0;
    logic [63:0] payload   = '0;
    logic [7:0]  rx_byte   = '0;
    logic        out_valid;
    logic        out_stall = 1'b1;
    logic [1:0]  result_kind;
    logic [7:0]  tx_byte;
    logic        last;
    logic [15:0] rx_can_id;
    logic [7:0]  rx_dlc;
    logic [63:0] rx_payload;
    logic [2:0]  rx_status;
    logic [31:0] sent_total;
    logic [31:0] good_total;
    logic [31:0] bad_total;
    int          fail_count;
    int          pending;

    t_cfg cfg_now;
    int   rx_fill_tb    = 0;
    int   items_sent    = 0;
    int   frames_sent   = 0;
    int   rejects       = 0;
    int   reports_made  = 0;
    int   cycle_count   = 0;
    bit   calm_in       = 1'b0;
    bit   calm_out      = 1'b0;

    can_over_uart_bridge_framer u_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_req_type    (req_type),
        .i_can_id      (can_id),
        .i_dlc         (dlc),
        .i_payload     (payload),
        .i_rx_byte     (rx_byte),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_result_kind (result_kind),
        .o_tx_byte     (tx_byte),
        .o_last        (last),
        .o_rx_can_id   (rx_can_id),
        .o_rx_dlc      (rx_dlc),
        .o_rx_payload  (rx_payload),
        .o_rx_status   (rx_status),
        .o_sent_total  (sent_total),
        .o_good_total  (good_total),
        .o_bad_total   (bad_total)
    );

    framer_monitor #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES),
        .FRAME_BYTES   (FRAME_BYTES)
    ) u_framer_mon (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_req_type    (req_type),
        .i_can_id      (can_id),
        .i_dlc         (dlc),
        .i_payload     (payload),
        .i_rx_byte     (rx_byte),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_result_kind (result_kind),
        .i_tx_byte     (tx_byte),
        .i_last        (last),
        .i_rx_can_id   (rx_can_id),
        .i_rx_dlc      (rx_dlc),
        .i_rx_payload  (rx_payload),
        .i_rx_status   (rx_status),
        .i_sent_total  (sent_total),
        .i_good_total  (good_total),
        .i_bad_total   (bad_total),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d beats still outstanding",
                     cycle_count, pending);
            $display("Verification failed");
            $finish;
        end
    end

    // output side: random hold-off before each beat, with calm stretches
    initial begin
        int hold;
        @(posedge clk);
        forever begin
            if ($urandom_range(0, 19) == 0) calm_out = ~calm_out;
            hold = calm_out ? 0 : $urandom_range(0, 9);
            if (hold != 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    // returns at the accepting edge with valid still high, so the next beat can follow
    task automatic drive_item(input logic [1:0] req, input logic [15:0] id,
                              input logic [7:0] d, input logic [63:0] pl,
                              input logic [7:0] b);
        int gap;
        gap = calm_in ? 0 : $urandom_range(0, 9);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= req;
        can_id   <= id;
        dlc      <= d;
        payload  <= pl;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        items_sent++;
        case (req)
            REQ_SEND: begin
                if (d > PAYLOAD_BYTES) rejects++;
                else frames_sent++;
            end
            REQ_BYTE: begin
                rx_fill_tb++;
                if (rx_fill_tb == FRAME_BYTES) begin
                    reports_made++;
                    rx_fill_tb = 0;
                end
            end
            REQ_IDLE: begin
                reports_made++;
                rx_fill_tb = 0;
            end
            default: ;
        endcase
    endtask

    task automatic send_can(input logic [15:0] id, input logic [7:0] d, input logic [63:0] pl);
        drive_item(REQ_SEND, id, d, pl, 8'($urandom));
    endtask

    task automatic feed_byte(input logic [7:0] b);
        drive_item(REQ_BYTE, 16'($urandom), 8'($urandom), {$urandom, $urandom}, b);
    endtask

    task automatic send_idle();
        drive_item(REQ_IDLE, 16'($urandom), 8'($urandom), {$urandom, $urandom},
                   8'($urandom));
    endtask

    // a frame built for the current settings, optionally damaged
    task automatic feed_frame(input t_flaw flaw);
        logic [7:0] fr [FRAME_BYTES];
        logic [7:0] sum;
        int         keep;
        if (rx_fill_tb != 0) send_idle();
        fr[0] = cfg_now.sync_first;
        fr[1] = cfg_now.sync_second;
        fr[2] = cfg_now.type_inbound;
        fr[3] = 8'($urandom);
        fr[4] = 8'($urandom);
        fr[5] = 8'(PAYLOAD_BYTES);
        for (int i = 0; i < PAYLOAD_BYTES; i++) fr[HDR_BYTES + i] = 8'($urandom);
        case (flaw)
            FLAW_SYNC_FIRST:  fr[0] ^= 8'($urandom_range(1, 255));
            FLAW_SYNC_SECOND: fr[1] ^= 8'($urandom_range(1, 255));
            FLAW_TYPE:        fr[2] ^= 8'($urandom_range(1, 255));
            FLAW_DLC_OVER:    fr[5] = 8'($urandom_range(PAYLOAD_BYTES + 1, 255));
            FLAW_DLC_SHORT:   fr[5] = 8'($urandom_range(0, PAYLOAD_BYTES - 1));
            default: ;
        endcase
        sum = 8'h00;
        for (int i = 2; i < FRAME_BYTES - 1; i++) sum ^= fr[i];
        fr[FRAME_BYTES - 1] = sum;
        // a bad checksum on top of another flaw checks the order of the checks
        if (flaw == FLAW_CHECKSUM || (flaw != FLAW_NONE && $urandom_range(0, 2) == 0))
            fr[FRAME_BYTES - 1] ^= 8'($urandom_range(1, 255));
        keep = (flaw == FLAW_TRUNCATE) ? $urandom_range(1, FRAME_BYTES - 1) : FRAME_BYTES;
        for (int i = 0; i < keep; i++) feed_byte(fr[i]);
        if (flaw == FLAW_TRUNCATE) send_idle();
    endtask

    // drain everything owed, then let any byte still in flight clear the pipe
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_SYNC_FIRST:    cfg_now.sync_first    = val;
            CFG_SYNC_SECOND:   cfg_now.sync_second   = val;
            CFG_TYPE_OUTBOUND: cfg_now.type_outbound = val;
            CFG_TYPE_INBOUND:  cfg_now.type_inbound  = val;
            default: ;
        endcase
    endtask

    task automatic set_regs(input logic [7:0] s1, input logic [7:0] s2,
                            input logic [7:0] t_out, input logic [7:0] t_in);
        write_reg(CFG_SYNC_FIRST, s1);
        write_reg(CFG_SYNC_SECOND, s2);
        write_reg(CFG_TYPE_OUTBOUND, t_out);
        write_reg(CFG_TYPE_INBOUND, t_in);
    endtask

    initial begin
        int start_items;
        int start_reports;
        int pick;
        cfg_now = {8'd170, 8'd85, 8'd1, 8'd2};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset settings, every request type, field extremes
        send_idle();
        send_can(16'h0000, 8'd0, '1);
        send_can(16'hFFFF, 8'd8, '1);
        send_can(16'h1234, 8'd9, {$urandom, $urandom});
        send_can(16'($urandom), 8'd255, '0);
        drive_item(REQ_UNUSED, '1, '1, '1, '1);
        send_can(16'h1234, 8'd3, {$urandom, $urandom});
        feed_frame(FLAW_NONE);
        feed_byte(cfg_now.sync_first);
        feed_byte(cfg_now.sync_second);
        send_idle();

        for (int phase = 0; phase < 4; phase++) begin
            settle();
            case (phase)
                0: set_regs(8'h00, 8'hFF, 8'h00, 8'hFF);
                1: set_regs(8'hFF, 8'h00, 8'hFF, 8'h00);
                2: set_regs(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
                default: set_regs(8'd170, 8'd85, 8'd1, 8'd2);
            endcase
            start_items   = items_sent;
            start_reports = reports_made;
            while (items_sent - start_items < 25 || reports_made - start_reports < 2) begin
                if ($urandom_range(0, 7) == 0) calm_in = ~calm_in;
                pick = $urandom_range(0, 99);
                if (pick < 30) begin
                    if ($urandom_range(0, 4) == 0)
                        send_can(16'($urandom), 8'($urandom_range(PAYLOAD_BYTES + 1, 255)),
                                 {$urandom, $urandom});
                    else
                        send_can(16'($urandom), 8'($urandom_range(0, PAYLOAD_BYTES)),
                                 {$urandom, $urandom});
                end else if (pick < 70) begin
                    if ($urandom_range(0, 9) < 4) feed_frame(FLAW_NONE);
                    else feed_frame(t_flaw'($urandom_range(FLAW_SYNC_FIRST, FLAW_TRUNCATE)));
                end else if (pick < 82) begin
                    send_idle();
                end else if (pick < 94) begin
                    repeat ($urandom_range(1, 5)) feed_byte(8'($urandom));
                end else begin
                    drive_item(REQ_UNUSED, 16'($urandom), 8'($urandom), {$urandom, $urandom},
                               8'($urandom));
                end
            end
        end
        settle();

        $display("%0d requests over five register settings: %0d frames sent, %0d sends refused,",
                 items_sent, frames_sent, rejects);
        $display("%0d receive reports checked, %0d beat failures", reports_made, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// File: files.f
src/cub_pkg.sv
src/cub_front.sv
src/cub_queue.sv
src/cub_back.sv
src/can_over_uart_bridge_framer.sv
tb/sv/framer_monitor.sv
tb/sv/tb_top.sv
